### hw/rtl/rgbhsl_pkg.sv
// Package for the RGB to HSL pixel converter.
// Holds field widths, divider sizes and the max-channel sector type.
// No dependencies.
`timescale 1ns / 1ps

package rgbhsl_pkg;

    localparam int CH_W      = 8;
    localparam int DATA_W    = 3 * CH_W;
    localparam int DIV_STEPS = CH_W;
    localparam int HNUM_W    = 19;
    localparam int HDIV_W    = 11;
    localparam int SNUM_W    = 16;
    localparam int SUM_W     = CH_W + 1;

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

endpackage

### hw/rtl/rgb_to_hsl_pixel.sv
// Top level of the RGB to HSL pixel converter.
// Depends on rgbhsl_pkg for widths and the sector type.
//
// Usage: pixels enter on the slave stream (s_axis) as red, green and blue
// bytes and leave on the master stream (m_axis) as hue, saturation and
// lightness bytes, one result beat for every input beat, in order.
// The datapath is an eleven stage pipeline: channel sort, difference and
// numerator build, scaling by 255, then eight restoring divide steps that
// each settle one quotient bit for hue and saturation in parallel.
// Throughput is one pixel per cycle while the receiver keeps tready high;
// each stage takes a new beat whenever it is empty or its successor moves,
// so bubbles are squeezed out during a stall.
// When the receiver drops tready the pipeline fills and then holds; no beat
// is lost or repeated, and input is refused only once all stages are full.
// Synchronous active-low reset clears all stage valid bits; the data
// registers are not reset.
`timescale 1ns / 1ps

module rgb_to_hsl_pixel (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // Fields from bit 0: red[7:0], green[15:8], blue[23:16].
    input  logic [rgbhsl_pkg::DATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // Fields from bit 0: hue[7:0], saturation[15:8], lightness[23:16].
    output logic [rgbhsl_pkg::DATA_W-1:0]  m_axis_tdata
);

    localparam int CH_W   = rgbhsl_pkg::CH_W;
    localparam int NDIV   = rgbhsl_pkg::DIV_STEPS;
    localparam int HNUM_W = rgbhsl_pkg::HNUM_W;
    localparam int HDIV_W = rgbhsl_pkg::HDIV_W;
    localparam int SNUM_W = rgbhsl_pkg::SNUM_W;
    localparam int SUM_W  = rgbhsl_pkg::SUM_W;
    localparam int NST    = 3 + NDIV;

    logic [NST-1:0] r_v;
    logic [NST-1:0] w_vin;
    logic [NST:0]   w_rdy;

    always_comb begin
        w_rdy[NST] = m_axis_tready;
        for (int k = NST - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign w_vin = {r_v[NST-2:0], s_axis_tvalid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= w_vin[k];
                end
            end
        end
    end

    assign s_axis_tready = w_rdy[0];
    assign m_axis_tvalid = r_v[NST-1];

    // Stage 0: sort the channels, pick the max-channel sector and the hue difference.
    logic [CH_W-1:0]        w_r, w_g, w_b;
    logic [CH_W-1:0]        n_mx, n_mn;
    rgbhsl_pkg::t_sector    n_sec;
    logic [SUM_W-1:0]       n_diff;
    logic [CH_W-1:0]        r_mx, r_mn;
    rgbhsl_pkg::t_sector    r_sec;
    logic [SUM_W-1:0]       r_diff;

    assign w_r = s_axis_tdata[CH_W-1:0];
    assign w_g = s_axis_tdata[2*CH_W-1:CH_W];
    assign w_b = s_axis_tdata[3*CH_W-1:2*CH_W];

    always_comb begin
        if (w_r >= w_g && w_r >= w_b) begin
            n_sec  = rgbhsl_pkg::SEC_RED;
            n_mx   = w_r;
            n_diff = {1'b0, w_g} - {1'b0, w_b};
        end else if (w_g >= w_b) begin
            n_sec  = rgbhsl_pkg::SEC_GREEN;
            n_mx   = w_g;
            n_diff = {1'b0, w_b} - {1'b0, w_r};
        end else begin
            n_sec  = rgbhsl_pkg::SEC_BLUE;
            n_mx   = w_b;
            n_diff = {1'b0, w_r} - {1'b0, w_g};
        end
        if (w_r <= w_g && w_r <= w_b) begin
            n_mn = w_r;
        end else if (w_g <= w_b) begin
            n_mn = w_g;
        end else begin
            n_mn = w_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_mx   <= n_mx;
            r_mn   <= n_mn;
            r_sec  <= n_sec;
            r_diff <= n_diff;
        end
    end

    // Stage 1: range, lightness, saturation divisor and hue numerator.
    logic [CH_W-1:0]   n_d;
    logic [SUM_W-1:0]  w_sum;
    logic [CH_W-1:0]   n_den;
    logic [HDIV_W-1:0] w_base;
    logic [HDIV_W-1:0] n_num;
    logic [CH_W-1:0]   r_d, r_den, r_lt1;
    logic [HDIV_W-1:0] r_num;

    always_comb begin
        n_d   = r_mx - r_mn;
        w_sum = {1'b0, r_mx} + {1'b0, r_mn};
        if (w_sum > SUM_W'(2**CH_W - 1)) begin
            n_den = CH_W'(SUM_W'(2 * (2**CH_W - 1)) - w_sum);
        end else begin
            n_den = w_sum[CH_W-1:0];
        end
        case (r_sec)
            rgbhsl_pkg::SEC_RED: begin
                w_base = r_diff[SUM_W-1] ? HDIV_W'(6 * n_d) : '0;
            end
            rgbhsl_pkg::SEC_GREEN: begin
                w_base = HDIV_W'(n_d) << 1;
            end
            rgbhsl_pkg::SEC_BLUE: begin
                w_base = HDIV_W'(n_d) << 2;
            end
            default: begin
                w_base = '0;
            end
        endcase
        n_num = w_base + {{(HDIV_W-SUM_W){r_diff[SUM_W-1]}}, r_diff};
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_d   <= n_d;
            r_den <= n_den;
            r_num <= n_num;
            r_lt1 <= w_sum[SUM_W-1:1];
        end
    end

    // Stage 2: scale numerators by 255 and form the divisors.
    logic [HNUM_W-1:0] n_hn, r_hn;
    logic [HDIV_W-1:0] n_hdiv, r_hdiv;
    logic [SNUM_W-1:0] n_sn, r_sn;
    logic [CH_W-1:0]   n_sdiv, r_sdiv;
    logic [CH_W-1:0]   r_lt2;

    always_comb begin
        if (r_d == '0) begin
            n_hn   = '0;
            n_hdiv = HDIV_W'(1);
            n_sn   = '0;
            n_sdiv = CH_W'(1);
        end else begin
            n_hn   = (HNUM_W'(r_num) << CH_W) - HNUM_W'(r_num);
            n_hdiv = (HDIV_W'(r_d) << 2) + (HDIV_W'(r_d) << 1);
            n_sn   = (SNUM_W'(r_d) << CH_W) - SNUM_W'(r_d);
            n_sdiv = r_den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_hn   <= n_hn;
            r_hdiv <= n_hdiv;
            r_sn   <= n_sn;
            r_sdiv <= n_sdiv;
            r_lt2  <= r_lt1;
        end
    end

    // Stages 3 and up: restoring division, most significant quotient bit first.
    logic [HNUM_W-1:0] w_hrem_i [NDIV];
    logic [HDIV_W-1:0] w_hdiv_i [NDIV];
    logic [CH_W-1:0]   w_hq_i   [NDIV];
    logic [SNUM_W-1:0] w_srem_i [NDIV];
    logic [CH_W-1:0]   w_sdiv_i [NDIV];
    logic [CH_W-1:0]   w_sq_i   [NDIV];
    logic [CH_W-1:0]   w_lt_i   [NDIV];

    logic [HNUM_W-1:0] r_hrem [NDIV];
    logic [HDIV_W-1:0] r_hdv  [NDIV];
    logic [CH_W-1:0]   r_hq   [NDIV];
    logic [SNUM_W-1:0] r_srem [NDIV];
    logic [CH_W-1:0]   r_sdv  [NDIV];
    logic [CH_W-1:0]   r_sq   [NDIV];
    logic [CH_W-1:0]   r_lt   [NDIV];

    assign w_hrem_i[0] = r_hn;
    assign w_hdiv_i[0] = r_hdiv;
    assign w_hq_i[0]   = '0;
    assign w_srem_i[0] = r_sn;
    assign w_sdiv_i[0] = r_sdiv;
    assign w_sq_i[0]   = '0;
    assign w_lt_i[0]   = r_lt2;

    for (genvar j = 0; j < NDIV; j++) begin : g_div
        localparam int B = NDIV - 1 - j;

        logic [HNUM_W-1:0] w_hsh;
        logic [SNUM_W-1:0] w_ssh;
        logic [HNUM_W-1:0] n_hrem;
        logic [SNUM_W-1:0] n_srem;
        logic [CH_W-1:0]   n_hq, n_sq;

        if (j > 0) begin : g_link
            assign w_hrem_i[j] = r_hrem[j-1];
            assign w_hdiv_i[j] = r_hdv[j-1];
            assign w_hq_i[j]   = r_hq[j-1];
            assign w_srem_i[j] = r_srem[j-1];
            assign w_sdiv_i[j] = r_sdv[j-1];
            assign w_sq_i[j]   = r_sq[j-1];
            assign w_lt_i[j]   = r_lt[j-1];
        end

        always_comb begin
            w_hsh = HNUM_W'(w_hdiv_i[j]) << B;
            w_ssh = SNUM_W'(w_sdiv_i[j]) << B;
            if (w_hrem_i[j] >= w_hsh) begin
                n_hrem = w_hrem_i[j] - w_hsh;
                n_hq   = w_hq_i[j] | (CH_W'(1) << B);
            end else begin
                n_hrem = w_hrem_i[j];
                n_hq   = w_hq_i[j];
            end
            if (w_srem_i[j] >= w_ssh) begin
                n_srem = w_srem_i[j] - w_ssh;
                n_sq   = w_sq_i[j] | (CH_W'(1) << B);
            end else begin
                n_srem = w_srem_i[j];
                n_sq   = w_sq_i[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[3+j]) begin
                r_hrem[j] <= n_hrem;
                r_hdv[j]  <= w_hdiv_i[j];
                r_hq[j]   <= n_hq;
                r_srem[j] <= n_srem;
                r_sdv[j]  <= w_sdiv_i[j];
                r_sq[j]   <= n_sq;
                r_lt[j]   <= w_lt_i[j];
            end
        end
    end

    assign m_axis_tdata = {r_lt[NDIV-1], r_sq[NDIV-1], r_hq[NDIV-1]};

endmodule

### verif/rgb_hsl_checker.sv
// Scoreboard for the RGB to HSL pixel converter: watches both streams,
// predicts hue, saturation and lightness for every accepted pixel and
// compares them in order. Depends on rgbhsl_pkg for widths and the sector type.
`timescale 1ns / 1ps

module rgb_hsl_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    input  logic                          i_s_axis_tready,
    input  logic [rgbhsl_pkg::DATA_W-1:0] i_s_axis_tdata,
    input  logic                          i_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    input  logic [rgbhsl_pkg::DATA_W-1:0] i_m_axis_tdata,
    output int                            o_fail_count,
    output int                            o_pending
);

    localparam int CH_W = rgbhsl_pkg::CH_W;

    typedef struct packed {
        logic [CH_W-1:0] lightness;
        logic [CH_W-1:0] saturation;
        logic [CH_W-1:0] hue;
    } t_hsl;

    t_hsl hsl_expected[$];
    int   mismatches = 0;

    function automatic t_hsl predict_hsl(logic [CH_W-1:0] red, logic [CH_W-1:0] green,
                                         logic [CH_W-1:0] blue);
        int unsigned         r, g, b, mx, mn, d, sum, den, num;
        rgbhsl_pkg::t_sector sec;
        t_hsl                res;
        r = red;
        g = green;
        b = blue;
        mx = (r > g) ? r : g;
        mx = (mx > b) ? mx : b;
        mn = (r < g) ? r : g;
        mn = (mn < b) ? mn : b;
        d = mx - mn;
        sum = mx + mn;
        res = '0;
        res.lightness = CH_W'(sum >> 1);
        if (d != 0) begin
            den = (sum > 255) ? (510 - sum) : sum;
            res.saturation = CH_W'((d * 255) / den);
            if (mx == r) begin
                sec = rgbhsl_pkg::SEC_RED;
            end else if (mx == g) begin
                sec = rgbhsl_pkg::SEC_GREEN;
            end else begin
                sec = rgbhsl_pkg::SEC_BLUE;
            end
            case (sec)
                rgbhsl_pkg::SEC_RED: begin
                    num = (g >= b) ? (g - b) : (6 * d - (b - g));
                end
                rgbhsl_pkg::SEC_GREEN: begin
                    num = 2 * d + b - r;
                end
                default: begin
                    num = 4 * d + r - g;
                end
            endcase
            res.hue = CH_W'((num * 255) / (6 * d));
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_hsl want;
        t_hsl got;
        if (i_rst_n) begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = i_m_axis_tdata;
                if (hsl_expected.size() == 0) begin
                    $error("result beat %h with no pixel outstanding", i_m_axis_tdata);
                    mismatches++;
                end else begin
                    want = hsl_expected.pop_front();
                    if (got.hue !== want.hue) begin
                        $error("hue: expected %0d, actual %0d", want.hue, got.hue);
                        mismatches++;
                    end
                    if (got.saturation !== want.saturation) begin
                        $error("saturation: expected %0d, actual %0d",
                               want.saturation, got.saturation);
                        mismatches++;
                    end
                    if (got.lightness !== want.lightness) begin
                        $error("lightness: expected %0d, actual %0d",
                               want.lightness, got.lightness);
                        mismatches++;
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                hsl_expected.push_back(predict_hsl(i_s_axis_tdata[CH_W-1:0],
                                                   i_s_axis_tdata[2*CH_W-1:CH_W],
                                                   i_s_axis_tdata[3*CH_W-1:2*CH_W]));
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= hsl_expected.size();
    end

endmodule

### verif/testbench.sv
// Top of the RGB to HSL converter testbench: clock, reset, pixel stimulus with
// random gaps and receiver stalls, and the final verdict.
// Depends on rgbhsl_pkg, rgb_to_hsl_pixel and rgb_hsl_checker.
`timescale 1ns / 1ps

module testbench;

    localparam int CH_W   = rgbhsl_pkg::CH_W;
    localparam int DATA_W = rgbhsl_pkg::DATA_W;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [DATA_W-1:0] m_axis_tdata;
    int                fail_count;
    int                pending;

    bit no_idle        = 0;
    bit rx_hold_req    = 0;
    int rx_hold_cycles = 300;

    rgb_to_hsl_pixel dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    rgb_hsl_checker scoreboard (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #3000000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : int'($urandom_range(0, 11));
    endfunction

    function automatic logic [DATA_W-1:0] pack_rgb(int r, int g, int b);
        return {CH_W'(b), CH_W'(g), CH_W'(r)};
    endfunction

    // Mix of uniform pixels, greys, tied maxima and channels pinned at or next to the extremes.
    function automatic logic [DATA_W-1:0] random_pixel();
        int kind;
        int r, g, b, hi;
        kind = $urandom_range(0, 99);
        r = $urandom_range(0, 255);
        g = $urandom_range(0, 255);
        b = $urandom_range(0, 255);
        if (kind < 55) begin
            return pack_rgb(r, g, b);
        end else if (kind < 70) begin
            return pack_rgb(r, r, r);
        end else if (kind < 85) begin
            hi = $urandom_range(1, 255);
            r = r % hi;
            case ($urandom_range(0, 2))
                0: return pack_rgb(hi, hi, r);
                1: return pack_rgb(r, hi, hi);
                default: return pack_rgb(hi, r, hi);
            endcase
        end else begin
            if ($urandom_range(0, 1)) r = $urandom_range(0, 1) ? 255 : 0;
            if ($urandom_range(0, 1)) g = $urandom_range(0, 1) ? 254 : 1;
            if ($urandom_range(0, 1)) b = $urandom_range(0, 1) ? 255 : 0;
            return pack_rgb(r, g, b);
        end
    endfunction

    // Entered and left just after a falling edge.
    task automatic send_pixel(logic [DATA_W-1:0] pixel, int gap);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = pixel;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random(int count);
        repeat (count) send_pixel(random_pixel(), draw_gap());
    endtask

    initial begin
        int gap;
        bit hold_done;
        hold_done = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (rx_hold_req && !hold_done) begin
                m_axis_tready = 1'b0;
                repeat (rx_hold_cycles) @(negedge i_clk);
                hold_done = 1'b1;
            end
            gap = draw_gap();
            if (gap > 0) begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    initial begin
        logic [DATA_W-1:0] directed[$];
        int wait_cycles;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Extremes, pure and mixed primaries, greys, ties for the maximum,
        // the red sector wrap, and both sides of the lightness midpoint.
        directed = '{pack_rgb(0, 0, 0), pack_rgb(255, 255, 255), pack_rgb(128, 128, 128),
                     pack_rgb(255, 0, 0), pack_rgb(0, 255, 0), pack_rgb(0, 0, 255),
                     pack_rgb(255, 255, 0), pack_rgb(0, 255, 255), pack_rgb(255, 0, 255),
                     pack_rgb(1, 0, 0), pack_rgb(0, 0, 1), pack_rgb(254, 255, 255),
                     pack_rgb(255, 0, 1), pack_rgb(255, 1, 0), pack_rgb(128, 127, 127),
                     pack_rgb(128, 128, 127), pack_rgb(129, 127, 127), pack_rgb(200, 100, 50),
                     pack_rgb(50, 100, 200), pack_rgb(10, 200, 100), pack_rgb(255, 254, 0),
                     pack_rgb(0, 1, 255), pack_rgb(85, 170, 255), pack_rgb(0, 128, 255)};
        foreach (directed[i]) send_pixel(directed[i], draw_gap());

        send_random(400);

        // Receiver stalls long enough for the pipeline to fill and refuse input.
        rx_hold_req = 1'b1;
        repeat (60) send_pixel(random_pixel(), 0);

        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);

        no_idle = 1;
        send_random(300);
        no_idle = 0;

        send_random(500);
        s_axis_tvalid = 1'b0;

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 20000) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        repeat (30) @(negedge i_clk);
        if (pending != 0) begin
            $error("%0d results never arrived", pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/rgbhsl_pkg.sv
hw/rtl/rgb_to_hsl_pixel.sv
verif/rgb_hsl_checker.sv
verif/testbench.sv
